FILE: hdl/wld_pkg.sv
`timescale 1ns / 1ps

package wld_pkg;

    // defaults for the top-level parameters
    localparam int MAX_INTERP_DEF = 63;
    localparam int COORD_BITS_DEF = 24;

    // step register
    localparam int          STEP_BITS  = 16;
    localparam logic [15:0] STEP_RESET = 16'd100;

    // a segment with any axis delta at or above 2**BIG_SHIFT saturates
    localparam int BIG_SHIFT = 22;
    // magnitude width fed to the serial squarer
    localparam int SQ_MB     = 22;
    // width of the sum of squares and of the square search
    localparam int SUM_BITS  = 46;
    // width of the serial step*step product
    localparam int STEP_SQ_BITS = 2 * STEP_BITS;

endpackage

FILE: hdl/wld_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module wld_div #(
    parameter int NW = 24,
    parameter int DW = 7
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic          busy,
    output logic [NW-1:0] quot,
    output logic [DW-1:0] rem
);

    localparam int CB = $clog2(NW + 1);

    logic          busy_reg;
    logic [CB-1:0] cnt_reg;
    logic [NW-1:0] quo_reg;
    logic [DW-1:0] rem_reg;

    logic [DW:0]   trial;
    logic          ge;
    logic [DW:0]   diff;

    // shift in the next dividend bit and try a subtract
    assign trial = {rem_reg, quo_reg[NW-1]};
    assign ge    = trial >= {1'b0, divisor};
    assign diff  = trial - {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CB'(NW - 1))
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[NW-2:0], ge};
            rem_reg <= ge ? diff[DW-1:0] : trial[DW-1:0];
        end
    end

    assign busy = busy_reg;
    assign quot = quo_reg;
    assign rem  = rem_reg;

endmodule

FILE: hdl/waypoint_linear_densifier_top.sv
`timescale 1ns / 1ps

// Densifies a 3D waypoint stream. The first point of a path, and every point while
// step_length is zero, comes out unchanged when the output register is free. A later
// point closes a segment: n = clamp(floor(len/step_length), 1, MAX_INTERP) interior
// points come out, then the point itself; a repeat of the previous point gives
// nothing. A segment passes through a delta check, bit-serial squaring of each axis
// (skipped when a delta reaches 2**22 and n saturates), a square search for n,
// bit-serial division by n + 1, and then emission of one point per cycle while the
// output register is free. One point is processed at a time; the output register
// holds a result while the next waits.
module waypoint_linear_densifier_top #(
    parameter int MAX_INTERP = wld_pkg::MAX_INTERP_DEF,
    parameter int COORD_BITS = wld_pkg::COORD_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    // fields from bit 0: pos_x, pos_y, pos_z
    input  logic [((3*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
    // path_start
    input  logic                              s_axis_tuser,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // fields from bit 0: out_x, out_y, out_z
    output logic [((3*COORD_BITS+7)/8)*8-1:0] m_axis_tdata,
    // is_original
    output logic                              m_axis_tuser,
    // run_last
    output logic                              m_axis_tlast,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic                              cfg_we,
    input  logic [wld_pkg::STEP_BITS-1:0]     cfg_data
);

    localparam int CW = COORD_BITS;
    localparam int KW = $clog2(MAX_INTERP + 2);
    localparam int DWB = ((3*CW+7)/8)*8;
    localparam int SB = wld_pkg::SUM_BITS;
    localparam int MB = wld_pkg::SQ_MB;
    localparam int QB = wld_pkg::STEP_SQ_BITS;
    localparam int BB = $clog2(MB);

    typedef enum logic [2:0] {
        ST_IDLE, ST_CHK, ST_SQ, ST_SRCH, ST_DIVS, ST_DIVW, ST_EMIT, ST_ORIG
    } state_t;

    state_t state_reg;

    logic [wld_pkg::STEP_BITS-1:0] step_reg;
    logic                          have_prev_reg;
    logic signed [CW-1:0]          prev_reg [3];
    logic signed [CW-1:0]          cur_reg  [3];
    logic [CW-1:0]                 dmag_reg [3];
    logic                          dneg_reg [3];

    // squaring and search
    logic [1:0]    axis_reg;
    logic [BB-1:0] bit_reg;
    logic [SB-1:0] s_reg;
    logic [SB-1:0] msh_reg;
    logic [MB-1:0] mpl_reg;
    logic [QB-1:0] qacc_reg;
    logic [QB-1:0] qsh_reg;
    logic [wld_pkg::STEP_BITS-1:0] qmp_reg;
    logic [SB-1:0] sq_reg;
    logic [SB-1:0] inc_reg;
    logic [KW-1:0] n_reg;
    logic [KW-1:0] k_reg;

    // emission
    logic [CW-1:0] accq_reg [3];
    logic [KW-1:0] accr_reg [3];

    // output register
    logic          out_valid_reg;
    logic [CW-1:0] out_reg [3];
    logic          out_orig_reg;
    logic          out_last_reg;

    logic          slot_free;
    logic          out_load;
    logic [KW-1:0] dvs;
    logic          div_busy [3];
    logic [CW-1:0] div_q [3];
    logic [KW-1:0] div_r [3];

    logic signed [CW:0] dlt [3];
    logic [CW:0]        dabs [3];
    logic               big_any;
    logic               zero_all;
    logic [SB-1:0]      sq_next;
    logic [KW:0]        r_sum [3];
    logic [CW-1:0]      q_next [3];
    logic [KW-1:0]      r_next [3];
    logic signed [CW:0] pt [3];
    logic [MB-1:0]      mag_next;

    assign slot_free     = !out_valid_reg || m_axis_tready;
    assign out_load      = slot_free && (state_reg == ST_EMIT || state_reg == ST_ORIG);
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign dvs           = n_reg + 1'b1;

    // segment deltas and magnitudes
    always_comb
    begin
        big_any  = 1'b0;
        zero_all = 1'b1;
        for (int a = 0; a < 3; a++)
        begin
            dlt[a]  = {cur_reg[a][CW-1], cur_reg[a]} - {prev_reg[a][CW-1], prev_reg[a]};
            dabs[a] = dlt[a][CW] ? -dlt[a] : dlt[a];
            if ((dabs[a][CW-1:0] >> wld_pkg::BIG_SHIFT) != '0)
                big_any = 1'b1;
            if (dlt[a] != '0)
                zero_all = 1'b0;
        end
    end

    // next axis magnitude for the squarer
    always_comb
    begin
        case (axis_reg)
            2'd0:    mag_next = MB'(dmag_reg[1]);
            default: mag_next = MB'(dmag_reg[2]);
        endcase
    end

    assign sq_next = sq_reg + inc_reg;

    // accumulate k*|d|/(n+1) with rounding offset in the remainder
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            r_sum[a]  = {1'b0, accr_reg[a]} + {1'b0, div_r[a]};
            q_next[a] = accq_reg[a] + div_q[a];
            r_next[a] = r_sum[a][KW-1:0];
            if (r_sum[a] >= {1'b0, dvs})
            begin
                r_next[a] = KW'(r_sum[a] - {1'b0, dvs});
                q_next[a] = q_next[a] + 1'b1;
            end
            pt[a] = dneg_reg[a]
                  ? {prev_reg[a][CW-1], prev_reg[a]} - {1'b0, q_next[a]}
                  : {prev_reg[a][CW-1], prev_reg[a]} + {1'b0, q_next[a]};
        end
    end

    // one divider per axis
    for (genvar g = 0; g < 3; g++)
    begin : g_div
        wld_div #(
            .NW (CW),
            .DW (KW)
        ) u_div (
            .clk      (clk),
            .rst_n    (rst_n),
            .start    (state_reg == ST_DIVS),
            .dividend (dmag_reg[g]),
            .divisor  (dvs),
            .busy     (div_busy[g]),
            .quot     (div_q[g]),
            .rem      (div_r[g])
        );
    end

    // step register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= wld_pkg::STEP_RESET;
        else if (cfg_we)
            step_reg <= cfg_data;
    end

    // sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            have_prev_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int a = 0; a < 3; a++)
                prev_reg[a] <= '0;
        end
        else
        begin
            if (out_valid_reg && m_axis_tready && !out_load)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        for (int a = 0; a < 3; a++)
                            cur_reg[a] <= s_axis_tdata[a*CW +: CW];
                        if (s_axis_tuser || !have_prev_reg || step_reg == '0)
                            state_reg <= ST_ORIG;
                        else
                            state_reg <= ST_CHK;
                    end
                end
                ST_CHK:
                begin
                    for (int a = 0; a < 3; a++)
                    begin
                        dmag_reg[a] <= dabs[a][CW-1:0];
                        dneg_reg[a] <= dlt[a][CW];
                    end
                    axis_reg <= 2'd0;
                    bit_reg  <= '0;
                    s_reg    <= '0;
                    msh_reg  <= SB'(MB'(dabs[0][CW-1:0]));
                    mpl_reg  <= MB'(dabs[0][CW-1:0]);
                    qacc_reg <= '0;
                    qsh_reg  <= QB'(step_reg);
                    qmp_reg  <= step_reg;
                    n_reg    <= KW'(MAX_INTERP);
                    if (zero_all)
                        state_reg <= ST_IDLE;
                    else if (big_any)
                        state_reg <= ST_DIVS;
                    else
                        state_reg <= ST_SQ;
                end
                ST_SQ:
                begin
                    // shift-add: one multiplier bit per cycle
                    if (mpl_reg[0])
                        s_reg <= s_reg + msh_reg;
                    if (qmp_reg[0])
                        qacc_reg <= qacc_reg + qsh_reg;
                    qsh_reg <= qsh_reg << 1;
                    qmp_reg <= qmp_reg >> 1;
                    if (bit_reg == BB'(MB - 1))
                    begin
                        bit_reg  <= '0;
                        axis_reg <= axis_reg + 1'b1;
                        msh_reg  <= SB'(mag_next);
                        mpl_reg  <= mag_next;
                        if (axis_reg == 2'd2)
                        begin
                            sq_reg    <= SB'(qacc_reg);
                            inc_reg   <= SB'(qacc_reg) + (SB'(qacc_reg) << 1);
                            k_reg     <= KW'(1);
                            n_reg     <= KW'(1);
                            state_reg <= ST_SRCH;
                        end
                    end
                    else
                    begin
                        bit_reg <= bit_reg + 1'b1;
                        msh_reg <= msh_reg << 1;
                        mpl_reg <= mpl_reg >> 1;
                    end
                end
                ST_SRCH:
                begin
                    // (k+1)^2 q = k^2 q + (2k+1) q
                    if (k_reg == KW'(MAX_INTERP) || s_reg < sq_next)
                        state_reg <= ST_DIVS;
                    else
                    begin
                        k_reg   <= k_reg + 1'b1;
                        n_reg   <= k_reg + 1'b1;
                        sq_reg  <= sq_next;
                        inc_reg <= inc_reg + (SB'(qacc_reg) << 1);
                    end
                end
                ST_DIVS:
                begin
                    state_reg <= ST_DIVW;
                end
                ST_DIVW:
                begin
                    if (!div_busy[0])
                    begin
                        for (int a = 0; a < 3; a++)
                        begin
                            accq_reg[a] <= '0;
                            accr_reg[a] <= dvs >> 1;
                        end
                        k_reg     <= KW'(1);
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (slot_free)
                    begin
                        for (int a = 0; a < 3; a++)
                        begin
                            accq_reg[a] <= q_next[a];
                            accr_reg[a] <= r_next[a];
                            out_reg[a]  <= pt[a][CW-1:0];
                        end
                        out_valid_reg <= 1'b1;
                        out_orig_reg  <= 1'b0;
                        out_last_reg  <= 1'b0;
                        if (k_reg == n_reg)
                            state_reg <= ST_ORIG;
                        else
                            k_reg <= k_reg + 1'b1;
                    end
                end
                ST_ORIG:
                begin
                    if (slot_free)
                    begin
                        for (int a = 0; a < 3; a++)
                        begin
                            out_reg[a]  <= cur_reg[a];
                            prev_reg[a] <= cur_reg[a];
                        end
                        out_valid_reg <= 1'b1;
                        out_orig_reg  <= 1'b1;
                        out_last_reg  <= 1'b1;
                        have_prev_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_orig_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = DWB'({out_reg[2], out_reg[1], out_reg[0]});

`ifndef SYNTHESIS
    a_n_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> n_reg >= KW'(1) && n_reg <= KW'(MAX_INTERP))
        else $error("interior count out of range");

    a_k_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> k_reg >= KW'(1) && k_reg <= n_reg)
        else $error("emission index beyond interior count");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> accr_reg[0] < dvs && accr_reg[1] < dvs
                                 && accr_reg[2] < dvs)
        else $error("rounding remainder not below divisor");

    a_prev_set: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ORIG && slot_free) |=> have_prev_reg && out_last_reg)
        else $error("original point did not update previous point");
`endif

endmodule
